[src/kvrs_pkg.sv]
package kvrs_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(MAX_POINTS);
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int THR_BITS    = 17;
    localparam int PROD_BITS   = THR_BITS + COUNT_BITS;
    localparam int FRAC_SHIFT  = 16;

    // threshold of 1.0 in Q1.16
    localparam logic [THR_BITS-1:0] FRAC_ONE = THR_BITS'(65536);

    // configuration register indexes
    localparam logic [1:0] REG_SELECT_MODE  = 2'd0;
    localparam logic [1:0] REG_PREFER_LARGE = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    // request and result kinds
    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_QUERY    = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_ANSWER  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_THR  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_OUT_RD,
        S_OUT_LAT,
        S_INNER,
        S_EVAL,
        S_FINISH,
        S_QUERY
    } kvrs_state_t;

endpackage

[src/keypoint_value_range_select_core.sv]
// Loads may come back to back; a query reads the memory, then answers.
// The last load starts the range search, which scans the stored points once
// per candidate value through the single read port; a bad threshold or an
// empty set ends it at the check.
// Results are strobed for one cycle on done; the receiver cannot stall.
// rst_n (async, low) clears control state; the point store is not cleared.
module keypoint_value_range_select_core
    import kvrs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [THR_BITS-1:0]       cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic                      req_type,
    input  logic [VALUE_BITS-1:0]     key_value,
    input  logic                      prior_keep,
    input  logic                      last_point,
    input  logic [ADDR_BITS-1:0]      point_index,
    output logic                      done,
    output logic                      result_kind,
    output logic                      keep,
    output logic [VALUE_BITS-1:0]     range_low,
    output logic [VALUE_BITS-1:0]     range_high,
    output logic [COUNT_BITS-1:0]     kept_count,
    output logic [1:0]                status
);

    kvrs_state_t state_reg, state_next;

    logic                   select_mode_reg, prefer_large_reg;
    logic [THR_BITS-1:0]    threshold_reg;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   closed_reg, closed_next;
    logic                   ovf_reg, ovf_next;
    logic [VALUE_BITS-1:0]  low_reg, low_next, high_reg, high_next;
    logic [VALUE_BITS-1:0]  vmin_reg, vmin_next, vmax_reg, vmax_next;
    logic [COUNT_BITS-1:0]  i_reg, i_next, j_reg, j_next;
    logic [COUNT_BITS-1:0]  cum_reg, cum_next;
    logic                   pend_reg, pend_next;
    logic [VALUE_BITS-1:0]  v_reg, v_next, stop_reg, stop_next;
    logic [COUNT_BITS-1:0]  stop_cum_reg, stop_cum_next;
    logic                   found_reg, found_next;
    logic [PROD_BITS-1:0]   tn_reg, tn_next;
    logic                   qok_reg, qok_next;

    logic                   done_reg, done_next;
    logic                   kind_reg, kind_next;
    logic                   keep_reg, keep_next;
    logic [VALUE_BITS-1:0]  rlow_reg, rlow_next, rhigh_reg, rhigh_next;
    logic [COUNT_BITS-1:0]  kcnt_reg, kcnt_next;
    logic [1:0]             stat_reg, stat_next;

    logic                   accept, wr_en;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [VALUE_BITS-1:0]  rd_value;
    logic                   rd_keep;
    logic [COUNT_BITS-1:0]  cnt_eff;
    logic                   bad_thr, match, stops, better;

    kvrs_store u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (cnt_eff[ADDR_BITS-1:0]),
        .wr_value (key_value),
        .wr_keep  (prior_keep),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_keep  (rd_keep)
    );

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign cnt_eff = closed_reg ? '0 : count_reg;
    assign wr_en   = accept && (req_type == REQ_LOAD)
                     && (cnt_eff < COUNT_BITS'(MAX_POINTS));

    assign bad_thr = select_mode_reg ? (threshold_reg <= THR_BITS'(1))
                                     : (threshold_reg > FRAC_ONE);
    assign match   = prefer_large_reg ? (rd_value >= v_reg) : (rd_value <= v_reg);
    assign stops   = select_mode_reg
                     ? ({{(THR_BITS-COUNT_BITS){1'b0}}, cum_reg} > threshold_reg)
                     : ({1'b0, cum_reg, {FRAC_SHIFT{1'b0}}} > tn_reg);
    assign better  = !found_reg || (prefer_large_reg ? (v_reg > stop_reg)
                                                     : (v_reg < stop_reg));

    // read address: candidate index in S_OUT_RD, scan index in S_INNER, query index otherwise
    always_comb
    begin
        case (state_reg)
            S_OUT_RD: rd_addr = i_reg[ADDR_BITS-1:0];
            S_INNER:  rd_addr = j_reg[ADDR_BITS-1:0];
            default:  rd_addr = point_index;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_mode_reg  <= 1'b0;
            prefer_large_reg <= 1'b0;
            threshold_reg    <= FRAC_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SELECT_MODE:  select_mode_reg  <= cfg_data[0];
                REG_PREFER_LARGE: prefer_large_reg <= cfg_data[0];
                REG_THRESHOLD:    threshold_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            low_reg    <= '0;
            high_reg   <= '1;
            done_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            ovf_reg    <= ovf_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            done_reg   <= done_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        vmin_reg     <= vmin_next;
        vmax_reg     <= vmax_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cum_reg      <= cum_next;
        v_reg        <= v_next;
        stop_reg     <= stop_next;
        stop_cum_reg <= stop_cum_next;
        tn_reg       <= tn_next;
        qok_reg      <= qok_next;
        kind_reg     <= kind_next;
        keep_reg     <= keep_next;
        rlow_reg     <= rlow_next;
        rhigh_reg    <= rhigh_next;
        kcnt_reg     <= kcnt_next;
        stat_reg     <= stat_next;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        closed_next   = closed_reg;
        ovf_next      = ovf_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        vmin_next     = vmin_reg;
        vmax_next     = vmax_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cum_next      = cum_reg;
        pend_next     = 1'b0;
        v_next        = v_reg;
        stop_next     = stop_reg;
        stop_cum_next = stop_cum_reg;
        found_next    = found_reg;
        tn_next       = tn_reg;
        qok_next      = qok_reg;
        done_next     = 1'b0;
        kind_next     = kind_reg;
        keep_next     = keep_reg;
        rlow_next     = rlow_reg;
        rhigh_next    = rhigh_reg;
        kcnt_next     = kcnt_reg;
        stat_next     = stat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_LOAD))
                begin
                    // first load after a summary opens a new set
                    if (closed_reg)
                    begin
                        ovf_next  = 1'b0;
                        low_next  = '0;
                        high_next = '1;
                    end
                    closed_next = 1'b0;
                    count_next  = cnt_eff;
                    if (wr_en)
                    begin
                        count_next = cnt_eff + COUNT_BITS'(1);
                        if (cnt_eff == '0)
                        begin
                            vmin_next = key_value;
                            vmax_next = key_value;
                        end
                        else
                        begin
                            if (key_value < vmin_reg) vmin_next = key_value;
                            if (key_value > vmax_reg) vmax_next = key_value;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_point)
                    begin
                        state_next = S_CHECK;
                    end
                end
                else if (accept)
                begin
                    qok_next   = ({1'b0, point_index} < count_reg);
                    state_next = S_QUERY;
                end
            end

            S_CHECK:
            begin
                tn_next     = PROD_BITS'(threshold_reg) * PROD_BITS'(count_reg);
                i_next      = '0;
                found_next  = 1'b0;
                closed_next = 1'b1;
                low_next    = '0;
                high_next   = '1;
                kind_next   = KIND_SUMMARY;
                keep_next   = 1'b0;
                rlow_next   = '0;
                rhigh_next  = '1;
                if (bad_thr)
                begin
                    kcnt_next  = count_reg;
                    stat_next  = ST_BAD_THR;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    kcnt_next  = '0;
                    stat_next  = ST_EMPTY;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end

            S_OUT_RD:
            begin
                state_next = S_OUT_LAT;
            end

            S_OUT_LAT:
            begin
                v_next     = rd_value;
                j_next     = '0;
                cum_next   = '0;
                state_next = S_INNER;
            end

            // scan all points, one read a cycle, compare in the cycle after the read
            S_INNER:
            begin
                if (pend_reg && match)
                begin
                    cum_next = cum_reg + COUNT_BITS'(1);
                end
                if (j_reg < count_reg)
                begin
                    j_next    = j_reg + COUNT_BITS'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (stops && better)
                begin
                    stop_next     = v_reg;
                    stop_cum_next = cum_reg;
                    found_next    = 1'b1;
                end
                i_next = i_reg + COUNT_BITS'(1);
                if (i_reg + COUNT_BITS'(1) == count_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end

            S_FINISH:
            begin
                if (!found_reg)
                begin
                    low_next  = vmin_reg;
                    high_next = vmax_reg;
                    kcnt_next = count_reg;
                end
                else if (prefer_large_reg)
                begin
                    low_next  = stop_reg;
                    high_next = vmax_reg;
                    kcnt_next = stop_cum_reg;
                end
                else
                begin
                    low_next  = vmin_reg;
                    high_next = stop_reg;
                    kcnt_next = stop_cum_reg;
                end
                rlow_next  = low_next;
                rhigh_next = high_next;
                stat_next  = ovf_reg ? ST_OVERFLOW : ST_OK;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_QUERY:
            begin
                kind_next  = KIND_ANSWER;
                keep_next  = qok_reg && rd_keep && (rd_value >= low_reg)
                             && (rd_value <= high_reg);
                rlow_next  = low_reg;
                rhigh_next = high_reg;
                kcnt_next  = '0;
                stat_next  = ST_OK;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign keep        = keep_reg;
    assign range_low   = rlow_reg;
    assign range_high  = rhigh_reg;
    assign kept_count  = kcnt_reg;
    assign status      = stat_reg;

`ifndef SYNTHESIS
    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // empty set summary reports no kept points
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == KIND_SUMMARY && status == ST_EMPTY) |-> kept_count == '0)
        else $error("empty set with nonzero kept count");

    // answers carry neutral count and status
    a_answer_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == KIND_ANSWER) |-> (kept_count == '0 && status == ST_OK))
        else $error("answer carries count or status");

    // kept count never exceeds stored count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == KIND_SUMMARY) |-> kept_count <= count_reg)
        else $error("kept count above stored count");
`endif

endmodule

[src/kvrs_store.sv]
module kvrs_store
    import kvrs_pkg::*;
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_BITS-1:0]          wr_addr,
    input  logic [VALUE_BITS-1:0]         wr_value,
    input  logic                          wr_keep,
    input  logic [ADDR_BITS-1:0]          rd_addr,
    output logic [VALUE_BITS-1:0]         rd_value,
    output logic                          rd_keep
);

    logic [VALUE_BITS:0] mem [MAX_POINTS];
    logic [VALUE_BITS:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_keep, wr_value};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_value = rd_data_reg[VALUE_BITS-1:0];
    assign rd_keep  = rd_data_reg[VALUE_BITS];

endmodule

[tb/sv/keypoint_value_range_select_core_tb.sv]
`timescale 1ns / 100ps

module keypoint_value_range_select_core_tb;
    import kvrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000000;
    localparam int SETTLE_CYCLES  = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [THR_BITS-1:0]   cfg_data;
    logic                  start;
    logic                  busy;
    logic                  req_type;
    logic [VALUE_BITS-1:0] key_value;
    logic                  prior_keep;
    logic                  last_point;
    logic [ADDR_BITS-1:0]  point_index;
    logic                  done;
    logic                  result_kind;
    logic                  keep;
    logic [VALUE_BITS-1:0] range_low;
    logic [VALUE_BITS-1:0] range_high;
    logic [COUNT_BITS-1:0] kept_count;
    logic [1:0]            status;

    typedef struct packed {
        logic                  kind;
        logic                  keep;
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS-1:0] hi;
        logic [COUNT_BITS-1:0] cnt;
        logic [1:0]            st;
    } range_result_t;

    range_result_t pending_results[$];

    // shadow of the block's state
    logic                  mdl_count_mode;
    logic                  mdl_prefer_large;
    logic [THR_BITS-1:0]   mdl_threshold;
    logic [VALUE_BITS-1:0] mdl_values[MAX_POINTS];
    logic                  mdl_keeps[MAX_POINTS];
    int                    mdl_loaded;
    logic [VALUE_BITS-1:0] mdl_low;
    logic [VALUE_BITS-1:0] mdl_high;
    logic                  mdl_overflow;
    logic                  mdl_closed;

    int mismatches;
    int idle_cycles;
    int items_sent;

    keypoint_value_range_select_core dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // count how many stored values fall inside lo..hi
    function automatic int count_inside(logic [VALUE_BITS-1:0] lo,
                                        logic [VALUE_BITS-1:0] hi);
        int c;
        c = 0;
        for (int i = 0; i < mdl_loaded; i++)
            if (mdl_values[i] >= lo && mdl_values[i] <= hi)
                c++;
        return c;
    endfunction

    // quantile walk: sets mdl_low/mdl_high, returns status
    function automatic logic [1:0] find_range();
        logic [VALUE_BITS-1:0] vmin, vmax, v, stop_val;
        logic                  found, stops;
        int                    cum;
        mdl_low  = '0;
        mdl_high = '1;
        if ((!mdl_count_mode && mdl_threshold > FRAC_ONE) ||
            (mdl_count_mode && mdl_threshold <= 1))
            return ST_BAD_THR;
        if (mdl_loaded == 0)
            return ST_EMPTY;
        vmin = mdl_values[0];
        vmax = mdl_values[0];
        for (int i = 1; i < mdl_loaded; i++)
        begin
            if (mdl_values[i] < vmin) vmin = mdl_values[i];
            if (mdl_values[i] > vmax) vmax = mdl_values[i];
        end
        found    = 1'b0;
        stop_val = '0;
        for (int i = 0; i < mdl_loaded; i++)
        begin
            v   = mdl_values[i];
            cum = 0;
            for (int j = 0; j < mdl_loaded; j++)
                if (mdl_prefer_large ? (mdl_values[j] >= v) : (mdl_values[j] <= v))
                    cum++;
            if (mdl_count_mode)
                stops = longint'(cum) > longint'(mdl_threshold);
            else
                stops = longint'(cum) * 65536 > longint'(mdl_threshold) * mdl_loaded;
            if (stops &&
                (!found || (mdl_prefer_large ? (v > stop_val) : (v < stop_val))))
            begin
                stop_val = v;
                found    = 1'b1;
            end
        end
        if (!found)
        begin
            mdl_low  = vmin;
            mdl_high = vmax;
        end
        else if (mdl_prefer_large)
        begin
            mdl_low  = stop_val;
            mdl_high = vmax;
        end
        else
        begin
            mdl_low  = vmin;
            mdl_high = stop_val;
        end
        return mdl_overflow ? ST_OVERFLOW : ST_OK;
    endfunction

    // advance shadow state on one accepted item
    task automatic predict_item(logic rq, logic [VALUE_BITS-1:0] val, logic pk,
                                logic lst, logic [ADDR_BITS-1:0] idx);
        range_result_t r;
        logic [1:0]    st;
        r = '0;
        if (rq == REQ_LOAD)
        begin
            if (mdl_closed)
            begin
                mdl_loaded   = 0;
                mdl_overflow = 1'b0;
                mdl_low      = '0;
                mdl_high     = '1;
                mdl_closed   = 1'b0;
            end
            if (mdl_loaded < MAX_POINTS)
            begin
                mdl_values[mdl_loaded] = val;
                mdl_keeps[mdl_loaded]  = pk;
                mdl_loaded++;
            end
            else
                mdl_overflow = 1'b1;
            if (lst)
            begin
                st         = find_range();
                mdl_closed = 1'b1;
                r.kind     = KIND_SUMMARY;
                r.lo       = mdl_low;
                r.hi       = mdl_high;
                r.cnt      = (st == ST_EMPTY) ? '0
                             : COUNT_BITS'(count_inside(mdl_low, mdl_high));
                r.st       = st;
                pending_results = {pending_results, r};
            end
        end
        else
        begin
            r.kind = KIND_ANSWER;
            if (int'(idx) < mdl_loaded)
                r.keep = mdl_keeps[idx] && mdl_values[idx] >= mdl_low
                         && mdl_values[idx] <= mdl_high;
            r.lo = mdl_low;
            r.hi = mdl_high;
            pending_results = {pending_results, r};
        end
    endtask

    // present one item at the falling edge and hold it until accepted
    task automatic send_item(logic rq, logic [VALUE_BITS-1:0] val, logic pk, logic lst,
                             logic [ADDR_BITS-1:0] idx);
        logic accepted;
        @(negedge clk);
        start       = 1'b1;
        req_type    = rq;
        key_value   = val;
        prior_keep  = pk;
        last_point  = lst;
        point_index = idx;
        do
        begin
            @(posedge clk);
            accepted = !busy;
        end
        while (!accepted);
        predict_item(rq, val, pk, lst, idx);
        items_sent++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        idle_gap(1);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [THR_BITS-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_SELECT_MODE:  mdl_count_mode   = data[0];
            REG_PREFER_LARGE: mdl_prefer_large = data[0];
            default:          mdl_threshold    = data;
        endcase
    endtask

    task automatic configure(logic md, logic lg, logic [THR_BITS-1:0] thr);
        drain();
        write_reg(REG_SELECT_MODE, THR_BITS'(md));
        write_reg(REG_PREFER_LARGE, THR_BITS'(lg));
        write_reg(REG_THRESHOLD, thr);
    endtask

    // a small fixed set: extremes, duplicates, mixed prior keep bits
    task automatic load_fixed_set();
        send_item(REQ_LOAD, 32'h0000_0000, 1'b1, 1'b0, '0);
        send_item(REQ_LOAD, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
        send_item(REQ_LOAD, 32'h0000_0010, 1'b0, 1'b0, '0);
        send_item(REQ_LOAD, 32'h0000_0010, 1'b1, 1'b0, '0);
        send_item(REQ_LOAD, 32'h8000_0000, 1'b1, 1'b1, '0);
    endtask

    task automatic query_fixed_set();
        for (int i = 0; i < 5; i++)
            send_item(REQ_QUERY, '0, 1'b0, 1'b0, ADDR_BITS'(i));
    endtask

    task automatic test_directed();
        // query before anything was loaded
        send_item(REQ_QUERY, '0, 1'b0, 1'b0, '0);
        // default: fraction 1.0, range spans every value
        load_fixed_set();
        query_fixed_set();
        send_item(REQ_QUERY, '1, 1'b1, 1'b1, '1);
        // count mode, small count, from the small end and the large end
        configure(1'b1, 1'b0, 17'd2);
        load_fixed_set();
        query_fixed_set();
        configure(1'b1, 1'b1, 17'd2);
        load_fixed_set();
        query_fixed_set();
        // count threshold never reached
        configure(1'b1, 1'b1, 17'd100);
        load_fixed_set();
        // bad thresholds
        configure(1'b0, 1'b0, 17'd65537);
        load_fixed_set();
        configure(1'b1, 1'b0, 17'd1);
        load_fixed_set();
        configure(1'b1, 1'b0, 17'd0);
        send_item(REQ_LOAD, 32'h1234_5678, 1'b1, 1'b1, '0);
        // fraction zero stops at the largest value
        configure(1'b0, 1'b1, 17'd0);
        load_fixed_set();
        send_item(REQ_QUERY, '0, 1'b1, 1'b0, 10'd1);
    endtask

    function automatic logic [THR_BITS-1:0] pick_threshold(logic md);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return md ? 17'd1 : FRAC_ONE;
            2:       return md ? 17'h1FFFF : THR_BITS'($urandom_range(65537, 131071));
            default: return md ? THR_BITS'($urandom_range(2, 14))
                               : THR_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic test_random();
        int                    n, burst;
        logic [VALUE_BITS-1:0] val;
        logic                  md;
        while (items_sent < 640)
        begin
            // new settings every few sets, pausing until idle
            if ($urandom_range(0, 3) == 0)
            begin
                md = 1'($urandom);
                configure(md, 1'($urandom), pick_threshold(md));
            end
            n     = $urandom_range(1, 12);
            burst = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    val = $urandom;
                else
                    val = $urandom_range(0, 7) << $urandom_range(0, 28);
                send_item(REQ_LOAD, val, 1'($urandom), i == n - 1, 10'($urandom));
                if (--burst == 0)
                begin
                    burst = $urandom_range(1, 8);
                    idle_gap($urandom_range(0, 5));
                end
            end
            // queries, mostly in range, some noise
            repeat ($urandom_range(0, 10))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_item(REQ_QUERY, $urandom, 1'($urandom), 1'($urandom),
                              10'($urandom));
                else
                    send_item(REQ_QUERY, $urandom, 1'($urandom), 1'($urandom),
                              10'($urandom_range(0, n + 1)));
                if ($urandom_range(0, 2) == 0)
                    idle_gap($urandom_range(1, 6));
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        range_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d status=%0d", result_kind, status);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_kind !== exp_r.kind || keep !== exp_r.keep ||
                    range_low !== exp_r.lo || range_high !== exp_r.hi ||
                    kept_count !== exp_r.cnt || status !== exp_r.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"exp kind=%0d keep=%0d lo=%h hi=%h cnt=%0d st=%0d",
                                  " / got kind=%0d keep=%0d lo=%h hi=%h cnt=%0d st=%0d"},
                                 exp_r.kind, exp_r.keep, exp_r.lo, exp_r.hi,
                                 exp_r.cnt, exp_r.st,
                                 result_kind, keep, range_low, range_high,
                                 kept_count, status);
                end
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("keypoint_value_range_select_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        start        = 1'b0;
        req_type     = REQ_LOAD;
        key_value    = '0;
        prior_keep   = 1'b0;
        last_point   = 1'b0;
        point_index  = '0;
        mismatches   = 0;
        items_sent   = 0;
        mdl_count_mode   = 1'b0;
        mdl_prefer_large = 1'b0;
        mdl_threshold    = FRAC_ONE;
        mdl_loaded   = 0;
        mdl_low      = '0;
        mdl_high     = '1;
        mdl_overflow = 1'b0;
        mdl_closed   = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("keypoint_value_range_select_core: match");
        else
            $display("keypoint_value_range_select_core: mismatch");
        $finish;
    end

endmodule
